// ===== rtl/b2g_pkg.sv =====
// ----------------------------------------------------------------------------
// b2g_pkg
// Shared widths, register codes and configuration types for the
// blocked-to-global index remap.
// ----------------------------------------------------------------------------
package b2g_pkg;

    localparam int MAX_AXES    = 4;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 64;
    localparam int LOCAL_W     = 10;
    localparam int BLOCK_W     = 6;
    localparam int SIZE_W      = 11;
    localparam int COUNT_W     = 7;
    localparam int POS_W       = 16;
    localparam int SPAN_W      = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 7'd64;

    typedef logic [LOCAL_W-1:0] local_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [SIZE_W-1:0]  cfg_size_t;
    typedef logic [COUNT_W-1:0] cfg_count_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SPAN_W-1:0]  span_t;

    typedef enum logic [2:0] {
        REG_BLOCK_SIZE_AXIS0  = 3'd0,
        REG_BLOCK_SIZE_AXIS1  = 3'd1,
        REG_BLOCK_SIZE_AXIS2  = 3'd2,
        REG_BLOCK_SIZE_AXIS3  = 3'd3,
        REG_BLOCK_COUNT_AXIS0 = 3'd4,
        REG_BLOCK_COUNT_AXIS1 = 3'd5,
        REG_BLOCK_COUNT_AXIS2 = 3'd6,
        REG_BLOCK_COUNT_AXIS3 = 3'd7
    } reg_idx_t;

    // Effective (clamped) block sizes and counts
    typedef struct packed {
        cfg_size_t  [MAX_AXES-1:0] size;
        cfg_count_t [MAX_AXES-1:0] count;
    } cfg_t;

endpackage

// ===== rtl/b2g_in_if.sv =====
// ----------------------------------------------------------------------------
// b2g_in_if
// Element input channel: valid/ready handshake with one raw data element.
// ----------------------------------------------------------------------------
interface b2g_in_if;

    logic                             valid;
    logic                             ready;
    logic [b2g_pkg::IN_DATA_W-1:0]    element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);

endinterface

// ===== rtl/b2g_out_if.sv =====
// ----------------------------------------------------------------------------
// b2g_out_if
// Result channel: global index, passed-through element and step end flag.
// ----------------------------------------------------------------------------
interface b2g_out_if #(
    parameter int ADDR_BITS = 40
);

    logic                             valid;
    logic                             ready;
    logic [ADDR_BITS-1:0]             global_index;
    logic [b2g_pkg::OUT_DATA_W-1:0]   element_data;
    logic                             step_done;

    modport source (output valid, output global_index, output element_data,
                    output step_done, input ready);
    modport sink   (input valid, input global_index, input element_data,
                    input step_done, output ready);

endinterface

// ===== rtl/b2g_cfg.sv =====
// ----------------------------------------------------------------------------
// b2g_cfg
// APB register file, clamping of sizes and counts, and a registered chain
// that derives the per-axis global strides after each write.
// ----------------------------------------------------------------------------
module b2g_cfg #(
    parameter int AXES      = 4,
    parameter int ADDR_BITS = 40
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [b2g_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [b2g_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [b2g_pkg::APB_DATA_W-1:0]      prdata,
    output b2g_pkg::cfg_t                       cfg,
    output logic [AXES-1:0][ADDR_BITS-1:0]      stride,
    output logic                                settling
);

    localparam int SETTLE_W = $clog2(AXES + 1);

    b2g_pkg::cfg_size_t  [b2g_pkg::MAX_AXES-1:0] size_reg, size_next;
    b2g_pkg::cfg_count_t [b2g_pkg::MAX_AXES-1:0] count_reg, count_next;
    b2g_pkg::span_t      [AXES-1:0]              span_reg, span_next;
    logic [AXES-1:0][ADDR_BITS-1:0]              stride_reg, stride_next;
    logic [SETTLE_W-1:0]                         settle_reg, settle_next;

    b2g_pkg::reg_idx_t idx;
    logic              wr;

    assign idx = b2g_pkg::reg_idx_t'(paddr[b2g_pkg::APB_ADDR_W-1:2]);
    assign wr  = psel && penable && pwrite;

    always_comb
    begin
        size_next  = size_reg;
        count_next = count_reg;
        if (wr)
        begin
            unique case (idx)
                b2g_pkg::REG_BLOCK_SIZE_AXIS0:  size_next[0]  = pwdata[b2g_pkg::SIZE_W-1:0];
                b2g_pkg::REG_BLOCK_SIZE_AXIS1:  size_next[1]  = pwdata[b2g_pkg::SIZE_W-1:0];
                b2g_pkg::REG_BLOCK_SIZE_AXIS2:  size_next[2]  = pwdata[b2g_pkg::SIZE_W-1:0];
                b2g_pkg::REG_BLOCK_SIZE_AXIS3:  size_next[3]  = pwdata[b2g_pkg::SIZE_W-1:0];
                b2g_pkg::REG_BLOCK_COUNT_AXIS0: count_next[0] = pwdata[b2g_pkg::COUNT_W-1:0];
                b2g_pkg::REG_BLOCK_COUNT_AXIS1: count_next[1] = pwdata[b2g_pkg::COUNT_W-1:0];
                b2g_pkg::REG_BLOCK_COUNT_AXIS2: count_next[2] = pwdata[b2g_pkg::COUNT_W-1:0];
                b2g_pkg::REG_BLOCK_COUNT_AXIS3: count_next[3] = pwdata[b2g_pkg::COUNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            b2g_pkg::REG_BLOCK_SIZE_AXIS0:  prdata = b2g_pkg::APB_DATA_W'(size_reg[0]);
            b2g_pkg::REG_BLOCK_SIZE_AXIS1:  prdata = b2g_pkg::APB_DATA_W'(size_reg[1]);
            b2g_pkg::REG_BLOCK_SIZE_AXIS2:  prdata = b2g_pkg::APB_DATA_W'(size_reg[2]);
            b2g_pkg::REG_BLOCK_SIZE_AXIS3:  prdata = b2g_pkg::APB_DATA_W'(size_reg[3]);
            b2g_pkg::REG_BLOCK_COUNT_AXIS0: prdata = b2g_pkg::APB_DATA_W'(count_reg[0]);
            b2g_pkg::REG_BLOCK_COUNT_AXIS1: prdata = b2g_pkg::APB_DATA_W'(count_reg[1]);
            b2g_pkg::REG_BLOCK_COUNT_AXIS2: prdata = b2g_pkg::APB_DATA_W'(count_reg[2]);
            b2g_pkg::REG_BLOCK_COUNT_AXIS3: prdata = b2g_pkg::APB_DATA_W'(count_reg[3]);
        endcase
    end

    // Zero acts as one; oversized values saturate
    always_comb
    begin
        for (int a = 0; a < b2g_pkg::MAX_AXES; a++)
        begin
            if (size_reg[a] == '0)
                cfg.size[a] = b2g_pkg::SIZE_W'(1);
            else if (size_reg[a] > b2g_pkg::SIZE_LIMIT)
                cfg.size[a] = b2g_pkg::SIZE_LIMIT;
            else
                cfg.size[a] = size_reg[a];

            if (count_reg[a] == '0)
                cfg.count[a] = b2g_pkg::COUNT_W'(1);
            else if (count_reg[a] > b2g_pkg::COUNT_LIMIT)
                cfg.count[a] = b2g_pkg::COUNT_LIMIT;
            else
                cfg.count[a] = count_reg[a];
        end
    end

    // One multiply per stage along the stride chain
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            span_next[a] = b2g_pkg::SPAN_W'(cfg.size[a]) * b2g_pkg::SPAN_W'(cfg.count[a]);
        end
        stride_next[0] = ADDR_BITS'(1);
        for (int a = 1; a < AXES; a++)
        begin
            stride_next[a] = stride_reg[a-1] * ADDR_BITS'(span_reg[a-1]);
        end
    end

    always_comb
    begin
        if (wr)
            settle_next = SETTLE_W'(AXES);
        else if (settle_reg != '0)
            settle_next = settle_reg - SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < b2g_pkg::MAX_AXES; a++)
            begin
                size_reg[a]  <= b2g_pkg::SIZE_W'(1);
                count_reg[a] <= b2g_pkg::COUNT_W'(1);
            end
            for (int a = 0; a < AXES; a++)
            begin
                span_reg[a]   <= b2g_pkg::SPAN_W'(1);
                stride_reg[a] <= ADDR_BITS'(1);
            end
            settle_reg <= '0;
        end
        else
        begin
            size_reg   <= size_next;
            count_reg  <= count_next;
            span_reg   <= span_next;
            stride_reg <= stride_next;
            settle_reg <= settle_next;
        end
    end

    assign stride   = stride_reg;
    assign settling = (settle_reg != '0);

endmodule

// ===== rtl/b2g_front.sv =====
// ----------------------------------------------------------------------------
// b2g_front
// Accepts elements, snapshots the local and block coordinates, flags the
// end of a time step and advances both mixed-radix counters.
// ----------------------------------------------------------------------------
module b2g_front #(
    parameter int AXES      = 4,
    parameter int DATA_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    b2g_in_if.sink                  elements,
    input  b2g_pkg::cfg_t           cfg,
    input  logic                    settling,
    input  logic                    q_full,
    output logic                    q_push,
    output logic [DATA_BITS+AXES*(b2g_pkg::LOCAL_W+b2g_pkg::BLOCK_W):0] q_wdata
);

    b2g_pkg::local_t [AXES-1:0] local_reg, local_next;
    b2g_pkg::block_t [AXES-1:0] block_reg, block_next;
    logic [AXES-1:0]            loc_end;
    logic [AXES-1:0]            blk_end;
    logic                       done;
    logic                       accept;

    always_comb
    begin
        logic carry;
        for (int a = 0; a < AXES; a++)
        begin
            loc_end[a] = (b2g_pkg::SIZE_W'(local_reg[a]) + b2g_pkg::SIZE_W'(1))
                         >= cfg.size[a];
            blk_end[a] = (b2g_pkg::COUNT_W'(block_reg[a]) + b2g_pkg::COUNT_W'(1))
                         >= cfg.count[a];
        end

        carry = 1'b1;
        for (int a = 0; a < AXES; a++)
        begin
            local_next[a] = local_reg[a];
            if (carry)
                local_next[a] = loc_end[a] ? '0 : local_reg[a] + b2g_pkg::LOCAL_W'(1);
            carry = carry & loc_end[a];
        end
        for (int a = 0; a < AXES; a++)
        begin
            block_next[a] = block_reg[a];
            if (carry)
                block_next[a] = blk_end[a] ? '0 : block_reg[a] + b2g_pkg::BLOCK_W'(1);
            carry = carry & blk_end[a];
        end

        done = (&loc_end) & (&blk_end);
    end

    assign elements.ready = !q_full && !settling;
    assign accept         = elements.valid && elements.ready;
    assign q_push         = accept;
    assign q_wdata        = {elements.element_value[DATA_BITS-1:0], done, block_reg, local_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_reg <= '0;
            block_reg <= '0;
        end
        else if (accept)
        begin
            local_reg <= local_next;
            block_reg <= block_next;
        end
    end

endmodule

// ===== rtl/b2g_fifo.sv =====
// ----------------------------------------------------------------------------
// b2g_fifo
// Short flop-based queue between the front and the back.
// ----------------------------------------------------------------------------
module b2g_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int DEPTH = b2g_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

// ===== rtl/b2g_back.sv =====
// ----------------------------------------------------------------------------
// b2g_back
// Three-stage index pipeline: per-axis position, position times stride,
// sum into the output register.
// ----------------------------------------------------------------------------
module b2g_back #(
    parameter int AXES      = 4,
    parameter int DATA_BITS = 64,
    parameter int ADDR_BITS = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  logic [DATA_BITS+AXES*(b2g_pkg::LOCAL_W+b2g_pkg::BLOCK_W):0] q_rdata,
    output logic                            q_pop,
    input  b2g_pkg::cfg_t                   cfg,
    input  logic [AXES-1:0][ADDR_BITS-1:0]  stride,
    b2g_out_if.source                       results
);

    localparam int LOC_BITS   = AXES * b2g_pkg::LOCAL_W;
    localparam int COORD_BITS = AXES * (b2g_pkg::LOCAL_W + b2g_pkg::BLOCK_W);
    localparam int ENTRY_W    = DATA_BITS + COORD_BITS + 1;

    b2g_pkg::local_t [AXES-1:0] q_local;
    b2g_pkg::block_t [AXES-1:0] q_block;
    logic                       q_done;
    logic [DATA_BITS-1:0]       q_data;

    logic                            s1_valid_reg, s1_valid_next;
    b2g_pkg::pos_t [AXES-1:0]        pos_reg, pos_next;
    logic                            s1_done_reg;
    logic [DATA_BITS-1:0]            s1_data_reg;

    logic                            s2_valid_reg, s2_valid_next;
    logic [AXES-1:0][ADDR_BITS-1:0]  term_reg, term_next;
    logic                            s2_done_reg;
    logic [DATA_BITS-1:0]            s2_data_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]            index_reg, index_next;
    logic                            out_done_reg;
    logic [DATA_BITS-1:0]            out_data_reg;

    logic adv_out, adv_s2, adv_s1;

    assign q_local = q_rdata[LOC_BITS-1:0];
    assign q_block = q_rdata[COORD_BITS-1:LOC_BITS];
    assign q_done  = q_rdata[COORD_BITS];
    assign q_data  = q_rdata[ENTRY_W-1:COORD_BITS+1];

    assign adv_out = !out_valid_reg || results.ready;
    assign adv_s2  = !s2_valid_reg || adv_out;
    assign adv_s1  = !s1_valid_reg || adv_s2;
    assign q_pop   = !q_empty && adv_s1;

    always_comb
    begin
        logic [ADDR_BITS-1:0] acc;
        for (int a = 0; a < AXES; a++)
        begin
            pos_next[a] = b2g_pkg::POS_W'(b2g_pkg::SPAN_W'(q_local[a])
                          + b2g_pkg::SPAN_W'(cfg.size[a]) * b2g_pkg::SPAN_W'(q_block[a]));
            term_next[a] = ADDR_BITS'(pos_reg[a]) * stride[a];
        end
        acc = '0;
        for (int a = 0; a < AXES; a++)
        begin
            acc = acc + term_reg[a];
        end
        index_next = acc;

        s1_valid_next  = adv_s1  ? !q_empty     : s1_valid_reg;
        s2_valid_next  = adv_s2  ? s1_valid_reg : s2_valid_reg;
        out_valid_next = adv_out ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            pos_reg     <= pos_next;
            s1_done_reg <= q_done;
            s1_data_reg <= q_data;
        end
        if (adv_s2)
        begin
            term_reg    <= term_next;
            s2_done_reg <= s1_done_reg;
            s2_data_reg <= s1_data_reg;
        end
        if (adv_out)
        begin
            index_reg    <= index_next;
            out_done_reg <= s2_done_reg;
            out_data_reg <= s2_data_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.global_index = index_reg;
    assign results.element_data = b2g_pkg::OUT_DATA_W'(out_data_reg);
    assign results.step_done    = out_done_reg;

endmodule

// ===== rtl/blocked_to_global_index_remap_top.sv =====
// ----------------------------------------------------------------------------
// blocked_to_global_index_remap_top
// Maps elements streamed in block order to their linear global index.
//
// Usage:
//   elements: one raw data element per transaction, in block order with
//     axis 0 fastest, local coordinates inside block coordinates.
//   results: one transaction per element with global_index, the element
//     (masked to DATA_BITS) and step_done on the last element of a step.
//   APB: eight registers at byte address 4*i, block sizes then counts.
// Throughput is one element per cycle while the queue is not full and no
// stride recompute is pending, limited by the single counter update in
// the front. An accepted element passes through the queue, then through
// the registered position multiply, stride multiply and sum stages.
// After each register write, elements.ready stays low while the registered
// stride chain recomputes one multiply per cycle. Reset sets all registers
// to 1 and all coordinates to 0. When results stalls, the pipeline holds
// and the four-entry queue fills before elements.ready drops.
// ----------------------------------------------------------------------------
module blocked_to_global_index_remap_top #(
    parameter int AXES      = 4,
    parameter int DATA_BITS = 64,
    parameter int ADDR_BITS = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    b2g_in_if.sink                          elements,
    b2g_out_if.source                       results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b2g_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [b2g_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [b2g_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int ENTRY_W = DATA_BITS + AXES * (b2g_pkg::LOCAL_W + b2g_pkg::BLOCK_W) + 1;

    b2g_pkg::cfg_t                  cfg;
    logic [AXES-1:0][ADDR_BITS-1:0] stride;
    logic                           settling;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_empty;
    logic [ENTRY_W-1:0]             q_wdata;
    logic [ENTRY_W-1:0]             q_rdata;

    assign pready = 1'b1;

    b2g_cfg #(
        .AXES      (AXES),
        .ADDR_BITS (ADDR_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .stride   (stride),
        .settling (settling)
    );

    b2g_front #(
        .AXES      (AXES),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .elements (elements),
        .cfg      (cfg),
        .settling (settling),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    b2g_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    b2g_back #(
        .AXES      (AXES),
        .DATA_BITS (DATA_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .stride  (stride),
        .results (results)
    );

`ifndef SYNTHESIS
    a_no_accept_settling: assert property (@(posedge clk) disable iff (!rst_n)
        settling |-> !elements.ready)
        else $error("element accepted while strides recompute");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_write_settles: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> settling)
        else $error("register write did not hold off input");
`endif

endmodule
